### rtl/assert_macros.svh
// assertion macros shared by the walker rtl
// expects signals named clk and rst_n in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define AMR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, checked out of reset
`define AMR_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### rtl/amr_fsw_pkg.sv
// constants, tables and helpers for the amr frame stream walker
// no dependencies; used by amr_frame_stream_walker_core
package amr_fsw_pkg;

  // field and register widths
  localparam int LENGTH_BITS_DEF = 32;
  localparam int WIN_W           = 16;
  localparam int FRAME_W         = 21;
  localparam int CAUSE_W         = 3;
  localparam int CFG_ADDR_W      = 1;
  localparam int CFG_DATA_W      = 21;
  // result fields besides the length: valid, wideband, frame count, cause
  localparam int RES_FIXED_W     = 2 + FRAME_W + CAUSE_W;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_RESYNC_WINDOW = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_CAP     = 1'd1;

  // register reset values
  localparam logic [WIN_W-1:0]   RESYNC_WINDOW_RST = 16'd8192;
  localparam logic [FRAME_W-1:0] FRAME_CAP_RST     = 21'd2000000;

  // end causes
  localparam logic [CAUSE_W-1:0] CAUSE_WINDOW_END  = 3'd0;
  localparam logic [CAUSE_W-1:0] CAUSE_NO_DATA     = 3'd1;
  localparam logic [CAUSE_W-1:0] CAUSE_PADDING     = 3'd2;
  localparam logic [CAUSE_W-1:0] CAUSE_EARLY_BAD   = 3'd3;
  localparam logic [CAUSE_W-1:0] CAUSE_RESYNC_MISS = 3'd4;
  localparam logic [CAUSE_W-1:0] CAUSE_FRAME_CAP   = 3'd5;
  localparam logic [CAUSE_W-1:0] CAUSE_RESYNC_LIM  = 3'd6;

  // stream layout
  localparam int HDR_LEN      = 9;
  localparam int NB_FIRST_TOC = 6;
  localparam int WB_FIRST_TOC = 9;
  localparam int PAD_LOOK     = 3;

  localparam logic [3:0]         MODE_NO_DATA = 4'hF;
  localparam logic [FRAME_W-1:0] MIN_FRAMES   = 21'd4;
  localparam logic [2:0]         RESYNC_LIMIT = 3'd4;

  // wideband header "#!AMR-WB\n"
  localparam logic [7:0] WB_MAGIC [HDR_LEN] = '{
    8'h23, 8'h21, 8'h41, 8'h4D, 8'h52, 8'h2D, 8'h57, 8'h42, 8'h0A
  };

  // frame payload sizes per mode
  localparam logic [5:0] NB_SIZE [16] = '{
    6'd12, 6'd13, 6'd15, 6'd17, 6'd19, 6'd20, 6'd26, 6'd31,
    6'd5,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0
  };
  localparam logic [5:0] WB_SIZE [16] = '{
    6'd17, 6'd23, 6'd32, 6'd36, 6'd40, 6'd46, 6'd50, 6'd58,
    6'd60, 6'd5,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0
  };

  // payload size of the frame behind a toc byte
  function automatic logic [5:0] size_lookup(input logic wide, input logic [3:0] mode);
    return wide ? WB_SIZE[mode] : NB_SIZE[mode];
  endfunction

endpackage

### rtl/amr_frame_stream_walker_core.sv
// amr storage-format frame stream walker, top level
// depends on amr_fsw_pkg and assert_macros.svh
//
// channel  direction  handshake               payload
// in_*     slave      in_tvalid / in_tready   data_byte, lookahead_only (tuser), last (tlast)
// out_*    master     out_tvalid / out_tready stream_length, valid_res, wideband, frame_count,
//                                             end_cause
// cfg_*    write      cfg_wr_en               register index, write data
//
// one byte per cycle: an input register, then one walk update per byte
// after the byte with tlast, closing steps walk the trailing positions
// with the same walk logic; the result register loads on the last of them
// input is held off during those closing steps and while a result waits there
// synchronous reset clears control and walk state and loads register defaults
`include "assert_macros.svh"

module amr_frame_stream_walker_core #(
  parameter int LENGTH_BITS = amr_fsw_pkg::LENGTH_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // configuration writes
  input  logic                                   cfg_wr_en,
  input  logic [amr_fsw_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [amr_fsw_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
  // byte stream
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [7:0]                             in_tdata,   // [7:0] data_byte
  input  logic                                   in_tuser,   // [0] lookahead_only
  input  logic                                   in_tlast,
  // result
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // stream_length, valid_res, wideband, frame_count, end_cause, zero fill
  output logic [((LENGTH_BITS + amr_fsw_pkg::RES_FIXED_W + 7) / 8) * 8 - 1:0] out_tdata
);

  localparam int OUT_W = ((LENGTH_BITS + amr_fsw_pkg::RES_FIXED_W + 7) / 8) * 8;
  localparam int RES_W = LENGTH_BITS + amr_fsw_pkg::RES_FIXED_W;
  // position width leaves headroom above the reported length
  localparam int PW    = ((LENGTH_BITS > 32) ? LENGTH_BITS : 32) + 2;
  localparam logic [1:0] FLUSH_LAST = 2'd2;

  typedef enum logic [1:0] {PH_HEADER, PH_WALK, PH_RESYNC, PH_DONE} phase_t;
  typedef enum logic {CTL_RUN, CTL_FLUSH} ctl_t;

  // configuration
  logic [amr_fsw_pkg::WIN_W-1:0]   win_r;
  logic [amr_fsw_pkg::FRAME_W-1:0] cap_r;

  // input register
  logic       item_vld_r;
  logic [7:0] item_byte_r;
  logic       item_la_r;
  logic       item_last_r;

  // last three bytes, hist0 newest
  logic [7:0] hist0_r, hist1_r, hist2_r;

  // walk state
  logic [PW-1:0]                   bp_r;
  logic [PW-1:0]                   ntoc_r;
  logic [PW-1:0]                   scan_r;
  logic [PW-1:0]                   flen_r;
  logic [PW-1:0]                   wlen_r;
  logic [amr_fsw_pkg::FRAME_W-1:0] frames_r;
  logic                            real_r;
  logic [2:0]                      rc_r;
  logic [amr_fsw_pkg::CAUSE_W-1:0] cause_r;
  phase_t                          phase_r;
  logic                            closed_r;
  logic                            match_r;

  // control
  ctl_t       ctl_r;
  logic [1:0] fj_r;

  // result register
  logic                            out_vld_r;
  logic [LENGTH_BITS-1:0]          out_len_r;
  logic                            out_ok_r;
  logic                            out_wide_r;
  logic [amr_fsw_pkg::FRAME_W-1:0] out_frames_r;
  logic [amr_fsw_pkg::CAUSE_W-1:0] out_cause_r;

  // next values
  phase_t                          ph_nxt;
  logic [PW-1:0]                   ntoc_nxt, scan_nxt, flen_nxt;
  logic [amr_fsw_pkg::FRAME_W-1:0] frames_nxt;
  logic                            real_nxt;
  logic [2:0]                      rc_nxt;
  logic [amr_fsw_pkg::CAUSE_W-1:0] cause_nxt;
  logic                            match_nxt;
  logic [PW-1:0]                   bp_nxt;

  // datapath signals
  logic          in_acc, step_go, walk_upd, out_load;
  logic          wide_res;
  logic [PW-1:0] hdr_toc;
  logic          closed_now;
  logic [PW-1:0] wlen_now, step_e, flush_pos, flush_e, flush_wl;
  logic          ev_en;
  logic [PW-1:0] ev_e;
  logic [7:0]    ev_b0, ev_b1, ev_b2, ev_b3;
  phase_t        ph_res;
  logic [PW-1:0] ntoc_res;
  logic [3:0]    mode0;
  logic [5:0]    size0;
  logic [PW-1:0] win_eff;
  logic          do_toc;
  logic [amr_fsw_pkg::CAUSE_W-1:0] fin_cause;
  logic [PW-1:0]                   fin_len;
  logic [LENGTH_BITS-1:0]          len_sat;
  logic [RES_W-1:0]                res_word;

  // handshakes
  assign in_tready = (ctl_r == CTL_RUN) && !(item_vld_r && item_last_r);
  assign in_acc    = in_tvalid && in_tready;
  assign step_go   = item_vld_r && (ctl_r == CTL_RUN);
  assign out_load  = (ctl_r == CTL_FLUSH) && (fj_r == FLUSH_LAST) && (!out_vld_r || out_tready);
  assign walk_upd  = step_go || ((ctl_r == CTL_FLUSH) && (fj_r != FLUSH_LAST));

  // header decision and first toc position
  assign wide_res = match_r && (bp_r >= PW'(amr_fsw_pkg::HDR_LEN));
  assign hdr_toc  = wide_res ? PW'(amr_fsw_pkg::WB_FIRST_TOC) : PW'(amr_fsw_pkg::NB_FIRST_TOC);

  // header match and byte count for the item in the register
  assign match_nxt = (bp_r < PW'(amr_fsw_pkg::HDR_LEN)) ?
                     (match_r && (item_byte_r == amr_fsw_pkg::WB_MAGIC[bp_r[3:0]])) : match_r;
  assign bp_nxt    = (&bp_r) ? bp_r : bp_r + PW'(1);

  // window end: closes at the first lookahead byte
  assign closed_now = closed_r | item_la_r;
  assign wlen_now   = closed_r ? wlen_r : bp_r;
  assign step_e     = bp_r - PW'(amr_fsw_pkg::PAD_LOOK);

  // closing positions after the final byte
  assign flush_pos = bp_r + PW'(fj_r);
  assign flush_e   = flush_pos - PW'(amr_fsw_pkg::PAD_LOOK);
  assign flush_wl  = closed_r ? wlen_r : bp_r;

  // evaluation position and the four bytes from it
  always_comb begin
    ev_b0 = hist2_r;
    ev_b1 = hist1_r;
    ev_b2 = hist0_r;
    ev_b3 = item_byte_r;
    if (ctl_r == CTL_FLUSH) begin
      ev_e  = flush_e;
      ev_en = (flush_pos >= PW'(amr_fsw_pkg::HDR_LEN)) && (flush_e < flush_wl);
      case (fj_r)
        2'd0: begin
          ev_b0 = hist2_r;
          ev_b1 = hist1_r;
          ev_b2 = hist0_r;
          ev_b3 = 8'd0;
        end
        2'd1: begin
          ev_b0 = hist1_r;
          ev_b1 = hist0_r;
          ev_b2 = 8'd0;
          ev_b3 = 8'd0;
        end
        default: begin
          ev_b0 = hist0_r;
          ev_b1 = 8'd0;
          ev_b2 = 8'd0;
          ev_b3 = 8'd0;
        end
      endcase
    end else begin
      ev_e  = step_e;
      ev_en = step_go && (bp_r >= PW'(amr_fsw_pkg::HDR_LEN)) && (phase_r != PH_DONE) &&
              (!closed_now || (step_e < wlen_now));
    end
  end

  // phase as seen once the header is resolved
  assign ph_res   = (phase_r == PH_HEADER) ? PH_WALK : phase_r;
  assign ntoc_res = (phase_r == PH_HEADER) ? hdr_toc : ntoc_r;
  assign mode0    = ev_b0[6:3];
  assign size0    = amr_fsw_pkg::size_lookup(wide_res, mode0);
  assign win_eff  = (win_r == '0) ? PW'(1) : PW'(win_r);

  // one walk step at the evaluation position
  always_comb begin
    ph_nxt     = phase_r;
    ntoc_nxt   = ntoc_r;
    scan_nxt   = scan_r;
    flen_nxt   = flen_r;
    frames_nxt = frames_r;
    real_nxt   = real_r;
    rc_nxt     = rc_r;
    cause_nxt  = cause_r;
    do_toc     = 1'b0;
    if (ev_en) begin
      ph_nxt   = ph_res;
      ntoc_nxt = ntoc_res;
      case (ph_res)
        PH_WALK: begin
          if (ev_e == ntoc_res) do_toc = 1'b1;
        end
        PH_RESYNC: begin
          if (ev_e >= scan_r) begin
            ph_nxt    = PH_DONE;
            cause_nxt = amr_fsw_pkg::CAUSE_RESYNC_MISS;
            flen_nxt  = ntoc_res;
          end else if ((mode0 != amr_fsw_pkg::MODE_NO_DATA) && (size0 != 6'd0)) begin
            ntoc_nxt = ev_e;
            rc_nxt   = rc_r + 3'd1;
            if (rc_nxt >= amr_fsw_pkg::RESYNC_LIMIT) begin
              ph_nxt    = PH_DONE;
              cause_nxt = amr_fsw_pkg::CAUSE_RESYNC_LIM;
              flen_nxt  = ev_e;
            end else begin
              ph_nxt = PH_WALK;
              do_toc = 1'b1;
            end
          end
        end
        default: ;
      endcase
      // toc byte at the evaluation position
      if (do_toc) begin
        if (frames_r >= cap_r) begin
          ph_nxt    = PH_DONE;
          cause_nxt = amr_fsw_pkg::CAUSE_FRAME_CAP;
          flen_nxt  = ev_e;
        end else if (mode0 == amr_fsw_pkg::MODE_NO_DATA) begin
          ph_nxt    = PH_DONE;
          cause_nxt = amr_fsw_pkg::CAUSE_NO_DATA;
          flen_nxt  = ev_e + PW'(1);
        end else begin
          real_nxt = real_r | (ev_b0 != 8'd0);
          if (real_r && (frames_r >= amr_fsw_pkg::MIN_FRAMES) && (ev_b0 == 8'd0) &&
              (ev_b1 == 8'd0) && (ev_b2 == 8'd0) && (ev_b3 == 8'd0)) begin
            ph_nxt    = PH_DONE;
            cause_nxt = amr_fsw_pkg::CAUSE_PADDING;
            flen_nxt  = ev_e;
          end else if (size0 == 6'd0) begin
            if (frames_r < amr_fsw_pkg::MIN_FRAMES) begin
              ph_nxt    = PH_DONE;
              cause_nxt = amr_fsw_pkg::CAUSE_EARLY_BAD;
              flen_nxt  = ev_e;
            end else begin
              ph_nxt   = PH_RESYNC;
              scan_nxt = ev_e + win_eff;
            end
          end else begin
            ntoc_nxt   = ev_e + PW'(size0) + PW'(1);
            frames_nxt = frames_r + 21'd1;
            rc_nxt     = 3'd0;
          end
        end
      end
    end
  end

  // closing decision on the last walk step
  always_comb begin
    case (ph_nxt)
      PH_DONE: begin
        fin_cause = cause_nxt;
        fin_len   = flen_nxt;
      end
      PH_RESYNC: begin
        fin_cause = amr_fsw_pkg::CAUSE_RESYNC_MISS;
        fin_len   = ntoc_nxt;
      end
      PH_WALK: begin
        fin_cause = amr_fsw_pkg::CAUSE_WINDOW_END;
        fin_len   = ntoc_nxt;
      end
      default: begin
        fin_cause = amr_fsw_pkg::CAUSE_WINDOW_END;
        fin_len   = hdr_toc;
      end
    endcase
  end

  // saturate the length to the reported width
  assign len_sat = (fin_len[PW-1:LENGTH_BITS] != '0) ? '1 : fin_len[LENGTH_BITS-1:0];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= amr_fsw_pkg::RESYNC_WINDOW_RST;
      cap_r <= amr_fsw_pkg::FRAME_CAP_RST;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        amr_fsw_pkg::REG_RESYNC_WINDOW: win_r <= cfg_wr_data[amr_fsw_pkg::WIN_W-1:0];
        amr_fsw_pkg::REG_FRAME_CAP:     cap_r <= cfg_wr_data[amr_fsw_pkg::FRAME_W-1:0];
        default: ;
      endcase
    end
  end

  // control sequencer and registered valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r      <= CTL_RUN;
      fj_r       <= 2'd0;
      item_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (in_acc) begin
        item_vld_r <= 1'b1;
      end else if (step_go) begin
        item_vld_r <= 1'b0;
      end
      case (ctl_r)
        CTL_RUN: begin
          if (step_go && item_last_r) begin
            ctl_r <= CTL_FLUSH;
            fj_r  <= 2'd0;
          end
        end
        CTL_FLUSH: begin
          if (fj_r != FLUSH_LAST) begin
            fj_r <= fj_r + 2'd1;
          end else if (out_load) begin
            ctl_r <= CTL_RUN;
            fj_r  <= 2'd0;
          end
        end
        default: ctl_r <= CTL_RUN;
      endcase
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // walk state, back to start after each result
  always_ff @(posedge clk) begin
    if (!rst_n || out_load) begin
      bp_r     <= '0;
      ntoc_r   <= '0;
      scan_r   <= '0;
      flen_r   <= '0;
      wlen_r   <= '0;
      frames_r <= '0;
      real_r   <= 1'b0;
      rc_r     <= 3'd0;
      cause_r  <= amr_fsw_pkg::CAUSE_WINDOW_END;
      phase_r  <= PH_HEADER;
      closed_r <= 1'b0;
      match_r  <= 1'b1;
    end else begin
      if (walk_upd) begin
        phase_r  <= ph_nxt;
        ntoc_r   <= ntoc_nxt;
        scan_r   <= scan_nxt;
        flen_r   <= flen_nxt;
        frames_r <= frames_nxt;
        real_r   <= real_nxt;
        rc_r     <= rc_nxt;
        cause_r  <= cause_nxt;
      end
      if (step_go) begin
        bp_r     <= bp_nxt;
        match_r  <= match_nxt;
        closed_r <= closed_now;
        wlen_r   <= wlen_now;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_byte_r <= in_tdata;
      item_la_r   <= in_tuser;
      item_last_r <= in_tlast;
    end
    if (step_go) begin
      hist2_r <= hist1_r;
      hist1_r <= hist0_r;
      hist0_r <= item_byte_r;
    end
    if (out_load) begin
      out_len_r    <= len_sat;
      out_ok_r     <= (frames_nxt >= amr_fsw_pkg::MIN_FRAMES);
      out_wide_r   <= wide_res;
      out_frames_r <= frames_nxt;
      out_cause_r  <= fin_cause;
    end
  end

  // result packing, lowest field first
  assign res_word   = {out_cause_r, out_frames_r, out_wide_r, out_ok_r, out_len_r};
  assign out_tdata  = OUT_W'(res_word);
  assign out_tvalid = out_vld_r;

  // checks
  `AMR_ASSERT_IMP(a_flush_no_item, ctl_r == CTL_FLUSH, !item_vld_r)
  `AMR_ASSERT_NXT(a_result_only_at_close, (ctl_r == CTL_RUN) && !out_vld_r, !out_vld_r)
  `AMR_ASSERT_NXT(a_restart_after_result, out_load,
                  (bp_r == '0) && (phase_r == PH_HEADER) && (ctl_r == CTL_RUN))
  `AMR_ASSERT_NXT(a_header_bytes_no_walk, step_go && (bp_r < PW'(amr_fsw_pkg::HDR_LEN)),
                  phase_r == PH_HEADER)

endmodule

### tb/sv/tb.sv
// self-checking testbench for amr_frame_stream_walker_core: random amr byte streams,
// random handshake idling, a built-in walk predictor checked against every result word
// depends on amr_fsw_pkg and the rtl of the walker
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import amr_fsw_pkg::*;

  localparam int OUT_W = ((LENGTH_BITS_DEF + RES_FIXED_W + 7) / 8) * 8;
  localparam logic [15:0] DEF_WINDOW = 16'd8192;
  localparam logic [20:0] DEF_CAP = 21'd2000000;
  localparam int unsigned STALL_LIMIT = 2000;

  typedef enum logic [1:0] {SEEK_HEADER, WALK_TOC, SCAN_RESYNC, WALK_OVER} walk_state_t;

  // one result word, fields from the highest bit down as on out_tdata
  typedef struct packed {
    logic [2:0]  cause;
    logic [20:0] frames;
    logic        wide;
    logic        valid;
    logic [31:0] len;
  } walk_result_t;

  typedef struct packed {
    logic [7:0] data;
    logic       la;
    logic       lst;
  } byte_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = 8'h00;   // [7:0] data_byte
  logic in_tuser = 1'b0;          // [0] lookahead_only
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b1;
  // [31:0] stream_length, [32] valid_res, [33] wideband, [54:34] frame_count,
  // [57:55] end_cause, zero fill above
  logic [OUT_W-1:0] out_tdata;

  amr_frame_stream_walker_core DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // bytes waiting to be sent and results still owed by the block
  byte_item_t send_q[$];
  walk_result_t results_due[$];
  int unsigned items_queued = 0;
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;

  // register copies used by the walk predictor
  logic [15:0] win_cfg = DEF_WINDOW;
  logic [20:0] cap_cfg = DEF_CAP;

  // walk predictor state
  logic [7:0] hdr_q [9];
  logic [7:0] tail_q [4];
  longint unsigned byte_pos, toc_pos, scan_end, fin_len, win_len;
  int unsigned frames, resyncs;
  bit real_seen, wide, win_closed;
  walk_state_t walk;
  logic [2:0] why;

  // payload bytes behind a toc of the given mode
  function automatic int unsigned mode_bytes(bit wb, logic [3:0] m);
    if (wb) begin
      case (m)
        4'd0: return 17;
        4'd1: return 23;
        4'd2: return 32;
        4'd3: return 36;
        4'd4: return 40;
        4'd5: return 46;
        4'd6: return 50;
        4'd7: return 58;
        4'd8: return 60;
        4'd9: return 5;
        default: return 0;
      endcase
    end
    case (m)
      4'd0: return 12;
      4'd1: return 13;
      4'd2: return 15;
      4'd3: return 17;
      4'd4: return 19;
      4'd5: return 20;
      4'd6: return 26;
      4'd7: return 31;
      4'd8: return 5;
      default: return 0;
    endcase
  endfunction

  // "#!AMR-WB\n"
  function automatic logic [7:0] magic_byte(int i);
    case (i)
      0: return 8'h23;
      1: return 8'h21;
      2: return 8'h41;
      3: return 8'h4D;
      4: return 8'h52;
      5: return 8'h2D;
      6: return 8'h57;
      7: return 8'h42;
      default: return 8'h0A;
    endcase
  endfunction

  function automatic void stream_clear();
    for (int i = 0; i < 9; i++) hdr_q[i] = 8'h00;
    for (int i = 0; i < 4; i++) tail_q[i] = 8'h00;
    byte_pos = 0;
    toc_pos = 0;
    scan_end = 0;
    fin_len = 0;
    win_len = 0;
    frames = 0;
    resyncs = 0;
    real_seen = 1'b0;
    wide = 1'b0;
    win_closed = 1'b0;
    walk = SEEK_HEADER;
    why = CAUSE_WINDOW_END;
  endfunction

  // bytes not yet received read as zero
  function automatic logic [7:0] byte_at(longint unsigned p);
    return (p < byte_pos) ? tail_q[p % 4] : 8'h00;
  endfunction

  function automatic void close_walk(logic [2:0] c, longint unsigned len);
    why = c;
    fin_len = len;
    walk = WALK_OVER;
  endfunction

  function automatic void settle_header();
    bit match;
    if (walk != SEEK_HEADER) return;
    match = 1'b1;
    for (int i = 0; i < 9; i++)
      if (hdr_q[i] != magic_byte(i)) match = 1'b0;
    wide = match;
    toc_pos = match ? WB_FIRST_TOC : NB_FIRST_TOC;
    walk = WALK_TOC;
  endfunction

  function automatic void read_toc(longint unsigned p);
    logic [7:0] t;
    int unsigned sz;
    t = byte_at(p);
    if (frames >= cap_cfg) begin
      close_walk(CAUSE_FRAME_CAP, p);
      return;
    end
    if (t[6:3] == MODE_NO_DATA) begin
      close_walk(CAUSE_NO_DATA, p + 1);
      return;
    end
    if (t != 8'h00) real_seen = 1'b1;
    // zero toc with three zero bytes behind it is padding
    if (real_seen && frames >= 4 && t == 8'h00 && byte_at(p + 1) == 8'h00 &&
        byte_at(p + 2) == 8'h00 && byte_at(p + 3) == 8'h00) begin
      close_walk(CAUSE_PADDING, p);
      return;
    end
    sz = mode_bytes(wide, t[6:3]);
    if (sz == 0) begin
      if (frames < 4) begin
        close_walk(CAUSE_EARLY_BAD, p);
        return;
      end
      walk = SCAN_RESYNC;
      scan_end = p + ((win_cfg == 16'd0) ? 1 : win_cfg);
      return;
    end
    toc_pos = p + 1 + sz;
    frames++;
    resyncs = 0;
  endfunction

  function automatic void visit(longint unsigned e);
    logic [7:0] b;
    settle_header();
    if (walk == WALK_TOC) begin
      if (e == toc_pos) read_toc(e);
    end else if (walk == SCAN_RESYNC) begin
      b = byte_at(e);
      if (e >= scan_end) begin
        close_walk(CAUSE_RESYNC_MISS, toc_pos);
        return;
      end
      if (b[6:3] != MODE_NO_DATA && mode_bytes(wide, b[6:3]) > 0) begin
        toc_pos = e;
        resyncs = (resyncs + 1) & 7;
        if (resyncs >= 4) begin
          close_walk(CAUSE_RESYNC_LIM, e);
          return;
        end
        walk = WALK_TOC;
        read_toc(e);
      end
    end
  endfunction

  // advance the walk by one accepted word; returns 1 with the result on a last word
  function automatic bit walk_byte(logic [7:0] b, logic la, logic lst,
                                   output walk_result_t r);
    longint unsigned q, wl, e;
    r = '0;
    q = byte_pos;
    if (la && !win_closed) begin
      win_closed = 1'b1;
      win_len = q;
    end
    if (q < 9) hdr_q[int'(q)] = b;
    tail_q[q % 4] = b;
    byte_pos = q + 1;
    // positions are walked three bytes behind so that padding can look ahead
    if (q >= 9 && walk != WALK_OVER) begin
      e = q - 3;
      if (!win_closed || e < win_len) visit(e);
    end
    if (!lst) return 1'b0;
    // closing: walk the trailing positions up to the window end
    settle_header();
    wl = win_closed ? win_len : byte_pos;
    e = (byte_pos >= 9) ? byte_pos - 3 : NB_FIRST_TOC;
    while (e < wl && walk != WALK_OVER) begin
      visit(e);
      e++;
    end
    if (walk == SCAN_RESYNC) close_walk(CAUSE_RESYNC_MISS, toc_pos);
    else if (walk != WALK_OVER) close_walk(CAUSE_WINDOW_END, toc_pos);
    r.len = (fin_len > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : fin_len[31:0];
    r.valid = frames >= 4;
    r.wide = wide;
    r.frames = frames[20:0];
    r.cause = why;
    stream_clear();
    return 1'b1;
  endfunction

  // stimulus building
  function automatic void put(logic [7:0] b, logic la);
    byte_item_t w;
    w.data = b;
    w.la = la;
    w.lst = 1'b0;
    send_q.push_back(w);
    items_queued++;
  endfunction

  // mark the final word of the stream
  function automatic void seal();
    byte_item_t w;
    w = send_q.pop_back();
    w.lst = 1'b1;
    send_q.push_back(w);
  endfunction

  function automatic logic [7:0] rand_byte();
    return ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
  endfunction

  function automatic void put_header(bit wb);
    if (wb) begin
      for (int i = 0; i < 9; i++) put(magic_byte(i), 1'b0);
    end else begin
      for (int i = 0; i < 5; i++) put(magic_byte(i), 1'b0);
      put(8'h0A, 1'b0);
    end
  endfunction

  function automatic void put_frame(bit wb, logic [7:0] toc);
    put(toc, 1'b0);
    for (int i = 0; i < mode_bytes(wb, toc[6:3]); i++) put(rand_byte(), 1'b0);
  endfunction

  function automatic logic [7:0] toc_of(logic [3:0] m);
    return {1'($urandom_range(0, 1)), m, 3'($urandom_range(0, 7))};
  endfunction

  // small frames are favored so that streams stay short
  function automatic logic [3:0] good_mode(bit wb);
    if ($urandom_range(0, 1) == 1) return wb ? 4'd9 : 4'd8;
    return wb ? 4'($urandom_range(0, 9)) : 4'($urandom_range(0, 8));
  endfunction

  function automatic logic [3:0] bad_mode(bit wb);
    return wb ? 4'($urandom_range(10, 14)) : 4'($urandom_range(9, 14));
  endfunction

  // well-formed stream with random content and a random way to end
  function automatic void queue_stream();
    bit wb;
    int unsigned start, nfr, n;
    logic [7:0] b;
    start = send_q.size();
    wb = $urandom_range(0, 2) == 0;
    if ($urandom_range(0, 9) == 0) begin
      // near-miss header: one bit flipped in one magic byte
      n = $urandom_range(0, 8);
      for (int i = 0; i < 9; i++) begin
        b = magic_byte(i);
        if (i == n) b = b ^ (8'h01 << $urandom_range(0, 7));
        put(b, 1'b0);
      end
    end else begin
      put_header(wb);
    end
    nfr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : $urandom_range(4, 8);
    for (int i = 0; i < nfr; i++) put_frame(wb, toc_of(good_mode(wb)));
    case ($urandom_range(0, 5))
      1: begin
        put(toc_of(MODE_NO_DATA), 1'b0);
        repeat ($urandom_range(0, 3)) put(rand_byte(), 1'b0);
      end
      2: repeat ($urandom_range(4, 6)) put(8'h00, 1'b0);
      3: begin
        // bad toc, junk with bad modes, then frames again
        put(toc_of(bad_mode(wb)), 1'b0);
        repeat ($urandom_range(0, 6)) put(toc_of(bad_mode(wb)), 1'b0);
        repeat ($urandom_range(1, 3)) put_frame(wb, toc_of(good_mode(wb)));
        if ($urandom_range(0, 1) == 1) put(toc_of(MODE_NO_DATA), 1'b0);
      end
      4: begin
        n = $urandom_range(1, 10);
        while (n > 0 && send_q.size() > start + 1) begin
          void'(send_q.pop_back());
          items_queued--;
          n--;
        end
      end
      5: begin
        // zero toc that is not padding: a nonzero byte within the next three
        put(8'h00, 1'b0);
        n = $urandom_range(0, 2);
        for (int i = 0; i < mode_bytes(wb, 4'd0); i++)
          put((i == n) ? 8'($urandom_range(1, 255)) : 8'h00, 1'b0);
        put(toc_of(MODE_NO_DATA), 1'b0);
      end
      default: ;
    endcase
    if ($urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 3))
        put(($urandom_range(0, 1) == 1) ? 8'h00 : rand_byte(), 1'b1);
      if ($urandom_range(0, 7) == 0) put(rand_byte(), 1'b0);
    end
    seal();
  endfunction

  // random bytes and lookahead marks
  function automatic void queue_noise();
    repeat ($urandom_range(1, 30))
      put(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
    seal();
  endfunction

  function automatic void queue_random(int unsigned min_items, int unsigned min_streams);
    int unsigned start, streams;
    start = items_queued;
    streams = 0;
    while (items_queued - start < min_items || streams < min_streams) begin
      if ($urandom_range(0, 6) == 0) queue_noise();
      else queue_stream();
      streams++;
    end
  endfunction

  // idle draw with stretches of no idling
  function automatic int unsigned draw_gap(inout int unsigned calm);
    if (calm != 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(10, 60);
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  // input driver
  int unsigned in_wait = 0, in_calm = 0;
  always @(posedge clk) begin
    byte_item_t w;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_wait <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (in_wait != 0) begin
        in_tvalid <= 1'b0;
        in_wait <= in_wait - 1;
      end else if (send_q.size() != 0) begin
        w = send_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= w.data;
        in_tuser <= w.la;
        in_tlast <= w.lst;
        in_wait <= draw_gap(in_calm);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result ready: the drawn stall runs while a result waits
  int unsigned out_wait = 0, out_calm = 0;
  always @(posedge clk) begin
    int unsigned w;
    if (!rst_n) begin
      out_tready <= 1'b1;
      out_wait <= 0;
    end else if (out_tvalid && out_tready) begin
      w = draw_gap(out_calm);
      out_wait <= w;
      out_tready <= (w == 0);
    end else if (out_wait != 0 && out_tvalid) begin
      out_wait <= out_wait - 1;
      out_tready <= (out_wait == 1);
    end
  end

  // monitor: predict on accepted input words, check accepted result words
  always @(posedge clk) begin
    walk_result_t want, got;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[$bits(walk_result_t)-1:0];
        results_seen++;
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d arrived with none pending: len=%0d frames=%0d cause=%0d",
                     results_seen, got.len, got.frames, got.cause);
        end else begin
          want = results_due.pop_front();
          if (got.len !== want.len || got.valid !== want.valid || got.wide !== want.wide ||
              got.frames !== want.frames || got.cause !== want.cause) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"result %0d: expected len=%0d valid=%0b wide=%0b frames=%0d ",
                        "cause=%0d, got len=%0d valid=%0b wide=%0b frames=%0d cause=%0d"},
                       results_seen, want.len, want.valid, want.wide, want.frames,
                       want.cause, got.len, got.valid, got.wide, got.frames, got.cause);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (walk_byte(in_tdata, in_tuser, in_tlast, want)) results_due.push_back(want);
      end
    end
  end

  // watchdog on cycles without any handshake
  int unsigned quiet = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // wait until every word is sent and every result is back, then let the block drain
  task automatic settle();
    while (send_q.size() != 0 || in_tvalid || results_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr <= idx;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_RESYNC_WINDOW) win_cfg = val[15:0];
    else cap_cfg = val[20:0];
  endtask

  initial begin
    stream_clear();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed streams under reset register values
    // shortest stream: one byte
    put(8'h00, 1'b0);
    seal();
    // narrowband, four frames, all-ones toc reads as no-data
    put_header(1'b0);
    repeat (4) put_frame(1'b0, 8'h44);
    put(8'hFF, 1'b0);
    seal();
    // wideband, four frames, zero padding
    put_header(1'b1);
    repeat (4) put_frame(1'b1, 8'h4C);
    repeat (4) put(8'h00, 1'b0);
    seal();
    // bad mode before four frames
    put_header(1'b0);
    repeat (2) put_frame(1'b0, 8'h44);
    put(8'h48, 1'b0);
    put(8'h11, 1'b0);
    seal();
    // bad mode after four frames, junk, resync onto a valid toc
    put_header(1'b0);
    repeat (4) put_frame(1'b0, 8'hC4);
    put(8'h50, 1'b0);
    put(8'h68, 1'b0);
    put_frame(1'b0, 8'h44);
    seal();
    // frame reaching past the window, zero lookahead
    put_header(1'b0);
    repeat (4) put_frame(1'b0, 8'h04);
    put(8'h3C, 1'b0);
    put(8'hA5, 1'b0);
    repeat (3) put(8'h00, 1'b1);
    seal();
    // window closes inside the header
    put(8'h23, 1'b0);
    put(8'h21, 1'b1);
    put(8'h41, 1'b1);
    seal();
    queue_random(250, 10);

    // window of one and cap of four
    settle();
    write_reg(REG_RESYNC_WINDOW, 21'd1);
    write_reg(REG_FRAME_CAP, 21'd4);
    @(negedge clk);
    queue_random(250, 12);

    // largest values the registers hold
    settle();
    write_reg(REG_RESYNC_WINDOW, 21'd65535);
    write_reg(REG_FRAME_CAP, 21'h1FFFFF);
    @(negedge clk);
    queue_random(250, 12);

    // zero window and zero cap
    settle();
    write_reg(REG_RESYNC_WINDOW, 21'd0);
    write_reg(REG_FRAME_CAP, 21'd0);
    @(negedge clk);
    queue_random(60, 6);

    // short window, cap inside typical frame counts
    settle();
    write_reg(REG_RESYNC_WINDOW, 21'($urandom_range(2, 40)));
    write_reg(REG_FRAME_CAP, 21'($urandom_range(5, 9)));
    @(negedge clk);
    queue_random(250, 12);

    // back to reset values
    settle();
    write_reg(REG_RESYNC_WINDOW, 21'(DEF_WINDOW));
    write_reg(REG_FRAME_CAP, DEF_CAP);
    @(negedge clk);
    queue_random(200, 10);

    settle();
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/amr_fsw_pkg.sv
rtl/amr_frame_stream_walker_core.sv
tb/sv/tb.sv
